// ===== rtl/core/hcd_pkg.sv =====
// Package for the chunked-transfer decoder core.
// Holds the parse phase codes, result kinds and the result struct.
// No dependencies.
package hcd_pkg;

	typedef enum logic [2:0] {
		PH_SIZE  = 3'd0,
		PH_LF    = 3'd1,
		PH_DATA  = 3'd2,
		PH_SKIP1 = 3'd3,
		PH_SKIP2 = 3'd4,
		PH_DONE  = 3'd5,
		PH_ERR   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [4:0] HEX_NONE = 5'd16;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		kind_t      kind;
	} res_t;

endpackage

// ===== rtl/core/http_chunked_decoder_core.sv =====
// Top level of the chunked-transfer body decoder.
// Instantiates hcd_parser and hcd_out_reg; depends on hcd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_byte) carries raw bytes of a
//   chunked message body, one request per byte. Output channel
//   (out_valid / out_stall / out_byte / kind) carries the results: kind 0
//   is a payload byte, kind 1 marks the final zero-size chunk, kind 2 a
//   format error (non-hex size character, CR without LF, empty size line,
//   size over LEN_BITS bits). out_byte is zero unless kind is 0. Size lines,
//   their CR LF and the two trailer bytes after each chunk give no result.
//   Throughput: one byte per cycle unless the sink stalls. A taken byte
//   is parsed from the input register; its result loads into the result
//   register, which drives out_valid. The two registers split the two
//   channels, so one byte is still taken while a result waits.
//   Stall: when the sink holds out_stall with a result pending, the byte
//   in the input register waits and in_stall rises once that register is
//   full; nothing is lost.
//   Reset: arst_n clears both registers and returns the parser to the
//   start of a size line. After the end mark or an error the block
//   consumes further bytes silently until reset.
module http_chunked_decoder_core import hcd_pkg::*; #(
	parameter int LEN_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       slot_free;
	logic       fire;
	res_t       res;

	// Parse the held byte only when the result register can take its result.
	assign fire     = valid_s1 && slot_free;
	// Hold off the source only when the input register is full and cannot drain.
	assign in_stall = valid_s1 && !slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	hcd_parser #(.LEN_BITS(LEN_BITS)) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_byte (byte_s1),
		.res     (res)
	);

	hcd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.out_stall (out_stall),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.kind      (kind)
	);

	// Control result records never carry a byte value.
	a_ctrl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> out_byte == 8'd0)
		else $error("control result with nonzero byte");

	// After an end mark or error leaves, no result ever follows.
	a_terminal_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && kind != KIND_DATA |=> !out_valid)
		else $error("result after end or error");

	// Source is held off only while the input register is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without backlog");

endmodule

// ===== rtl/core/hcd_parser.sv =====
// Chunk framing state machine: phase, size/length counter, digit flag.
// Consumes one byte per fire strobe and forms at most one result.
// Depends on hcd_pkg.
module hcd_parser import hcd_pkg::*; #(
	parameter int LEN_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] in_byte,
	output res_t       res
);

	phase_t              phase_q, phase_d;
	logic [LEN_BITS-1:0] remaining_q, remaining_d;
	logic                digit_seen_q, digit_seen_d;
	logic [4:0]          hex_d;
	logic [LEN_BITS-1:0] rem_dec;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
		else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h61 + 8'd10);
		else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h41 + 8'd10);
		return v;
	endfunction

	assign hex_d   = hex_value(in_byte);
	assign rem_dec = remaining_q - LEN_BITS'(1);

	// Next state.
	always_comb begin
		phase_d      = phase_q;
		remaining_d  = remaining_q;
		digit_seen_d = digit_seen_q;
		case (phase_q)
			PH_SIZE: begin
				if (in_byte == CHAR_CR) begin
					phase_d = PH_LF;
				end else if (hex_d == HEX_NONE ||
				             remaining_q[LEN_BITS-1 -: 4] != 4'd0) begin
					phase_d = PH_ERR;
				end else begin
					remaining_d  = {remaining_q[LEN_BITS-5:0], hex_d[3:0]};
					digit_seen_d = 1'b1;
				end
			end
			PH_LF: begin
				if (in_byte != CHAR_LF || !digit_seen_q) phase_d = PH_ERR;
				else if (remaining_q == '0) phase_d = PH_DONE;
				else phase_d = PH_DATA;
			end
			PH_DATA: begin
				remaining_d = rem_dec;
				if (rem_dec == '0) phase_d = PH_SKIP1;
			end
			PH_SKIP1: phase_d = PH_SKIP2;
			PH_SKIP2: begin
				phase_d      = PH_SIZE;
				remaining_d  = '0;
				digit_seen_d = 1'b0;
			end
			default: phase_d = phase_q;
		endcase
	end

	// Result forming.
	always_comb begin
		res = '{valid: 1'b0, data: 8'd0, kind: KIND_DATA};
		case (phase_q)
			PH_SIZE: begin
				if (in_byte != CHAR_CR && (hex_d == HEX_NONE ||
				    remaining_q[LEN_BITS-1 -: 4] != 4'd0)) begin
					res.valid = 1'b1;
					res.kind  = KIND_ERR;
				end
			end
			PH_LF: begin
				if (in_byte != CHAR_LF || !digit_seen_q) begin
					res.valid = 1'b1;
					res.kind  = KIND_ERR;
				end else if (remaining_q == '0) begin
					res.valid = 1'b1;
					res.kind  = KIND_END;
				end
			end
			PH_DATA: begin
				res.valid = 1'b1;
				res.data  = in_byte;
			end
			default: res.valid = 1'b0;
		endcase
		res.valid = res.valid & fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIZE;
			remaining_q  <= '0;
			digit_seen_q <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			remaining_q  <= remaining_d;
			digit_seen_q <= digit_seen_d;
		end
	end

endmodule

// ===== rtl/core/hcd_out_reg.sv =====
// Result register of the decoder: holds one result until the sink takes it.
// Depends on hcd_pkg.
module hcd_out_reg import hcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  res_t       res,
	input  logic       out_stall,
	output logic       slot_free,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic [1:0] kind
);

	logic       valid_q;
	logic [7:0] data_q;
	kind_t      kind_q;

	assign slot_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res.valid) begin
			data_q <= res.data;
			kind_q <= res.kind;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = data_q;
	assign kind      = kind_q;

endmodule

// ===== tb/http_chunked_decoder_core_tb.sv =====
// Self-checking testbench for http_chunked_decoder_core: drives one chunked body per run
// and checks each payload, end or error result against a built-in byte decoder.
// Depends on hcd_pkg and the core RTL only.
module http_chunked_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hcd_pkg::*;

	localparam int LEN_BITS     = 32;
	localparam int BODY_BYTES   = 1800;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 60;
	localparam int HOLD_CHUNK   = 64;

	// The body can end only once per reset, so each run picks one way to close it.
	typedef enum int {
		END_ZERO_CHUNK,
		END_BAD_CHAR,
		END_CR_NO_LF,
		END_EMPTY_LINE,
		END_OVERFLOW
	} ending_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} decoded_t;

	// Decoder of its own plus the queue of results it has produced but not yet seen.
	class chunk_scoreboard;
		phase_t                ph;
		logic [LEN_BITS-1:0]   size_left;
		bit                    have_digit;
		decoded_t              decoded_q[$];
		int                    mismatches;

		function new();
			ph = PH_SIZE;
			size_left = '0;
			have_digit = 0;
			mismatches = 0;
		endfunction

		static function logic [4:0] digit_value(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return 5'(c - "0");
			if (c >= "a" && c <= "f")
				return 5'(c - "a" + 8'd10);
			if (c >= "A" && c <= "F")
				return 5'(c - "A" + 8'd10);
			return HEX_NONE;
		endfunction

		function void queue_result(logic [7:0] b, kind_t k);
			decoded_t r;
			r.data = b;
			r.kind = k;
			decoded_q.push_back(r);
		endfunction

		function void format_error();
			ph = PH_ERR;
			queue_result(8'h00, KIND_ERR);
		endfunction

		// Advance the decoder by one accepted body byte.
		function void take_byte(logic [7:0] c);
			logic [4:0] d;
			case (ph)
				PH_SIZE: begin
					if (c == CHAR_CR) begin
						ph = PH_LF;
					end else begin
						d = digit_value(c);
						if (d == HEX_NONE || size_left[LEN_BITS-1 -: 4] != 4'd0) begin
							format_error();
						end else begin
							size_left = {size_left[LEN_BITS-5:0], d[3:0]};
							have_digit = 1;
						end
					end
				end
				PH_LF: begin
					if (c != CHAR_LF || !have_digit) begin
						format_error();
					end else if (size_left == '0) begin
						ph = PH_DONE;
						queue_result(8'h00, KIND_END);
					end else begin
						ph = PH_DATA;
					end
				end
				PH_DATA: begin
					size_left = size_left - 1'b1;
					if (size_left == '0)
						ph = PH_SKIP1;
					queue_result(c, KIND_DATA);
				end
				PH_SKIP1: ph = PH_SKIP2;
				PH_SKIP2: begin
					ph = PH_SIZE;
					size_left = '0;
					have_digit = 0;
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic [7:0] b, logic [1:0] k);
			decoded_t r;
			if (decoded_q.size() == 0) begin
				report($sformatf("unexpected result byte=%02h kind=%0d", b, k));
				return;
			end
			r = decoded_q.pop_front();
			if (k != r.kind)
				report($sformatf("kind %0d, expected %0d", k, r.kind));
			if (b != r.data)
				report($sformatf("byte %02h, expected %02h", b, r.data));
		endtask

		function int outstanding();
			return decoded_q.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] kind;

	chunk_scoreboard sb;
	int  sender_idle_pct = 11;
	int  sink_stall_pct  = 50;
	int  bytes_sent      = 0;
	int  cycle_count     = 0;
	bit  hold_req        = 0;
	bit  hold_done       = 0;

	http_chunked_decoder_core #(
		.LEN_BITS(LEN_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.kind     (kind)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both channels on the edge itself: values read here are the ones the core saw.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.take_byte(in_byte);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_byte, kind);
	end

	// Abort on a hung run, e.g. a result that never shows up.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Sink side: random stall per cycle, plus one long hold-off on request so the
	// result register and then the input register fill and in_stall rises.
	initial begin : sink
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Offer one request, idling first at the current rate; return once it is taken.
	// Keep in_valid high between back-to-back requests.
	task send_byte(input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
	endtask

	// Hex digit in random case.
	function logic [7:0] hex_char(logic [3:0] v);
		if (v < 4'd10)
			return "0" + 8'(v);
		return ($urandom_range(1) ? "A" : "a") + 8'(v) - 8'd10;
	endfunction

	// Size line: at least min_digits digits (pad with leading zeros), then CR LF.
	task send_size(input int unsigned size, input int min_digits);
		int ndig;
		ndig = 1;
		while (ndig < 8 && (size >> (4 * ndig)) != 0)
			ndig++;
		if (min_digits > ndig)
			ndig = min_digits;
		for (int i = ndig - 1; i >= 0; i--)
			send_byte(hex_char(4'(size >> (4 * i))));
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
	endtask

	// Trailer is skipped unchecked: mostly CR LF, sometimes junk.
	task send_trailer();
		if ($urandom_range(3) != 0) begin
			send_byte(CHAR_CR);
			send_byte(CHAR_LF);
		end else begin
			send_byte(8'($urandom));
			send_byte(8'($urandom));
		end
	endtask

	task send_chunk(input int unsigned size, input int min_digits);
		send_size(size, min_digits);
		repeat (size)
			send_byte(8'($urandom));
		send_trailer();
	endtask

	task send_random_digits(input int n);
		repeat (n)
			send_byte(hex_char(4'($urandom)));
	endtask

	// Close the body one of five ways, then push a few bytes the core must drop silently.
	task send_ending();
		ending_t how;
		logic [7:0] b;
		how = ending_t'($urandom_range(4));
		case (how)
			END_ZERO_CHUNK: send_size(0, $urandom_range(1, 8));
			END_BAD_CHAR: begin
				// Chunk extensions land here too.
				send_random_digits($urandom_range(0, 3));
				do
					b = $urandom_range(1) ? ";" : 8'($urandom);
				while (chunk_scoreboard::digit_value(b) != HEX_NONE || b == CHAR_CR);
				send_byte(b);
			end
			END_CR_NO_LF: begin
				send_random_digits($urandom_range(1, 3));
				send_byte(CHAR_CR);
				do
					b = 8'($urandom);
				while (b == CHAR_LF);
				send_byte(b);
			end
			END_EMPTY_LINE: begin
				send_byte(CHAR_CR);
				send_byte(CHAR_LF);
			end
			END_OVERFLOW: begin
				// Nonzero top digit, then one digit too many.
				send_byte(hex_char(4'($urandom_range(1, 15))));
				send_random_digits(8);
			end
			default: ;
		endcase
		repeat ($urandom_range(5, 20))
			send_byte(8'($urandom));
	endtask

	initial begin : main
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: data extremes, leading zeros at full width, junk trailer.
		send_size(2, 2);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		send_size(1, 8);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h00);

		// Random well-formed chunks; switch idle rates by thirds of the body.
		while (bytes_sent < BODY_BYTES) begin
			if (bytes_sent >= 2 * BODY_BYTES / 3) begin
				sender_idle_pct = 0;
				sink_stall_pct  = 0;
			end else if (bytes_sent >= BODY_BYTES / 3) begin
				sender_idle_pct = 50;
				sink_stall_pct  = 11;
			end
			if (sender_idle_pct == 0 && !hold_done) begin
				// Stream a long chunk into a sink that holds off.
				send_size(HOLD_CHUNK, 1);
				hold_req = 1;
				repeat (HOLD_CHUNK)
					send_byte(8'($urandom));
				send_trailer();
				hold_done = 1;
			end else begin
				send_chunk($urandom_range(6) == 0 ? $urandom_range(25, 200)
					: $urandom_range(1, 24),
					$urandom_range(3) == 0 ? $urandom_range(1, 8) : 1);
			end
		end
		send_ending();
		in_valid <= 1'b0;

		// Drain: wait for every queued result, then give the pipeline time to
		// show any stray one.
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hcd_pkg.sv
rtl/core/hcd_parser.sv
rtl/core/hcd_out_reg.sv
rtl/core/http_chunked_decoder_core.sv
tb/http_chunked_decoder_core_tb.sv
